>>> design/i2cm_pkg.sv
// Shared types, constants and the command program table for the I2C master.
// No dependencies; used by i2cm_seq and i2c_master_register_access_top.
package i2cm_pkg;

	// Bus recovery pulse count
	localparam logic [3:0] RECOVERY_PULSES = 4'd9;

	// Command codes on the operation field
	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_WRITE   = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;
	localparam logic [1:0] OP_RECOVER = 2'd3;

	// Configuration register indexes (byte address 4*i)
	localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
	localparam logic [1:0] REG_RECOVERY_TICKS = 2'd1;
	localparam logic [1:0] REG_ACK_TIMEOUT    = 2'd2;

	// Reset values of the configuration registers
	localparam logic [15:0] PHASE_TICKS_RST    = 16'd2;
	localparam logic [15:0] RECOVERY_TICKS_RST = 16'd20;
	localparam logic [7:0]  ACK_TIMEOUT_RST    = 8'd250;

	// Bus phases; recovery phases must stay last (timing select uses order)
	typedef enum logic [4:0] {
		PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
		PH_BT0, PH_BT1, PH_BT2,
		PH_AK0, PH_AK1, PH_AKP, PH_AK3, PH_AKF,
		PH_RD0, PH_RD1, PH_RD2, PH_NK0, PH_NK1,
		PH_SP0, PH_SP1, PH_SP2,
		PH_RC0, PH_RC1, PH_RC2, PH_RC3, PH_RC4
	} phase_t;

	// Parts of a command
	typedef enum logic [3:0] {
		SG_START, SG_DEV, SG_REG, SG_DATA, SG_DEV1, SG_READ, SG_STOP, SG_RECOVER, SG_END
	} stage_t;

	typedef struct packed {
		logic [15:0] phase_ticks;
		logic [15:0] recovery_phase_ticks;
		logic [7:0]  ack_timeout;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] read_data;
		logic       ack_error;
	} res_t;

	// Command program: the stage at a given step of a command
	function automatic stage_t program_stage(input logic [1:0] cmd, input logic [2:0] step);
		stage_t sg;
		sg = SG_END;
		case (cmd)
			OP_WRITE: begin
				case (step)
					3'd0: sg = SG_START;
					3'd1: sg = SG_DEV;
					3'd2: sg = SG_REG;
					3'd3: sg = SG_DATA;
					3'd4: sg = SG_STOP;
					default: sg = SG_END;
				endcase
			end
			OP_READ: begin
				case (step)
					3'd0: sg = SG_START;
					3'd1: sg = SG_DEV;
					3'd2: sg = SG_REG;
					3'd3: sg = SG_START;
					3'd4: sg = SG_DEV1;
					3'd5: sg = SG_READ;
					3'd6: sg = SG_STOP;
					default: sg = SG_END;
				endcase
			end
			OP_RECOVER: begin
				case (step)
					3'd0: sg = SG_RECOVER;
					default: sg = SG_END;
				endcase
			end
			default: sg = SG_END;
		endcase
		return sg;
	endfunction

endpackage

>>> design/i2c_master_register_access_top.sv
// Top level of the I2C master: APB configuration registers, request handshake
// and the result register. Depends on i2cm_pkg and i2cm_seq.
//
// Usage: each request on the input channel (in_valid / in_stall) is one bus
// tick carrying operation, addresses, write data and the sampled SDA level.
// operation starts a register write, a register read or a bus recovery and is
// only taken while no command is running. Each request gives exactly one
// result on the output channel (out_valid / out_stall): SCL and SDA drive,
// busy, done, the last read byte and the acknowledge error flag.
// The result of a request is registered: it is shown right after the edge
// that takes the request. Throughput is one request per cycle while out_stall
// holds no waiting result; the sequencer state and the result register update
// together at each accepted request.
// While out_stall holds a waiting result, in_stall is raised and the result
// stays put; a new request is taken in the same cycle the result leaves.
// Reset clears the sequencer to idle with both lines released and loads the
// configuration defaults (phase 2, recovery phase 20, ack timeout 250 ticks).
// Configuration is written through the APB port, registers at 0x0, 0x4, 0x8.
module i2c_master_register_access_top (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  device_address,
	input  logic [7:0]  register_address,
	input  logic [7:0]  write_data,
	input  logic        sda_in,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_out,
	output logic        sda_out,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_error,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import i2cm_pkg::*;

	cfg_t cfg_q;
	res_t res;
	res_t res_q;
	logic out_valid_q;
	logic accept;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks          <= PHASE_TICKS_RST;
			cfg_q.recovery_phase_ticks <= RECOVERY_TICKS_RST;
			cfg_q.ack_timeout          <= ACK_TIMEOUT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_PHASE_TICKS:    cfg_q.phase_ticks          <= pwdata[15:0];
				REG_RECOVERY_TICKS: cfg_q.recovery_phase_ticks <= pwdata[15:0];
				REG_ACK_TIMEOUT:    cfg_q.ack_timeout          <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			REG_PHASE_TICKS:    prdata = {16'd0, cfg_q.phase_ticks};
			REG_RECOVERY_TICKS: prdata = {16'd0, cfg_q.recovery_phase_ticks};
			REG_ACK_TIMEOUT:    prdata = {24'd0, cfg_q.ack_timeout};
			default:            prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// Take a request when the result register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	i2cm_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.tick_en          (accept),
		.cfg              (cfg_q),
		.operation        (operation),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.res              (res)
	);

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_out   = res_q.scl;
	assign sda_out   = res_q.sda;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign read_data = res_q.read_data;
	assign ack_error = res_q.ack_error;

endmodule

>>> design/i2cm_seq.sv
// Bus sequencer of the I2C master: phase state, bit shifter, tick timer, ack poll.
// Advances one bus tick per enabled cycle. Depends on i2cm_pkg.
module i2cm_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick_en,
	input  i2cm_pkg::cfg_t   cfg,
	input  logic [1:0]       operation,
	input  logic [7:0]       device_address,
	input  logic [7:0]       register_address,
	input  logic [7:0]       write_data,
	input  logic             sda_in,
	output i2cm_pkg::res_t   res
);
	import i2cm_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  bit_q, bit_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	logic [7:0]  ackw_q, ackw_d;
	logic [7:0]  dev_q, dev_d;
	logic [7:0]  reg_q, reg_d;
	logic [7:0]  data_q, data_d;
	logic [1:0]  cmd_q, cmd_d;
	logic [7:0]  recv_q, recv_d;
	logic        err_q, err_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic [2:0]  step_q, step_d;

	logic        fin;
	logic        enter;
	stage_t      enter_sg;
	logic        send;
	logic [7:0]  send_b;
	logic [16:0] tick_nx;
	logic [15:0] hold;
	logic [3:0]  bit_nx;
	logic [7:0]  shift_nx;

	// Hold state between ticks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			tick_q  <= '0;
			ackw_q  <= '0;
			dev_q   <= '0;
			reg_q   <= '0;
			data_q  <= '0;
			cmd_q   <= '0;
			recv_q  <= '0;
			err_q   <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			step_q  <= '0;
		end else if (tick_en) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			tick_q  <= tick_d;
			ackw_q  <= ackw_d;
			dev_q   <= dev_d;
			reg_q   <= reg_d;
			data_q  <= data_d;
			cmd_q   <= cmd_d;
			recv_q  <= recv_d;
			err_q   <= err_d;
			scl_q   <= scl_d;
			sda_q   <= sda_d;
			step_q  <= step_d;
		end
	end

	assign tick_nx  = {1'b0, tick_q} + 17'd1;
	assign hold     = (phase_q >= PH_RC0) ? cfg.recovery_phase_ticks : cfg.phase_ticks;
	assign bit_nx   = bit_q + 4'd1;
	assign shift_nx = {shift_q[6:0], 1'b0};

	// Next state for one tick
	always_comb begin
		phase_d  = phase_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		tick_d   = tick_q;
		ackw_d   = ackw_q;
		dev_d    = dev_q;
		reg_d    = reg_q;
		data_d   = data_q;
		cmd_d    = cmd_q;
		recv_d   = recv_q;
		err_d    = err_q;
		scl_d    = scl_q;
		sda_d    = sda_q;
		step_d   = step_q;
		fin      = 1'b0;
		enter    = 1'b0;
		enter_sg = SG_END;
		send     = 1'b0;
		send_b   = '0;

		if (phase_q == PH_IDLE) begin
			// Latch a new command
			if (operation != OP_NONE) begin
				cmd_d    = operation;
				dev_d    = device_address;
				reg_d    = register_address;
				data_d   = write_data;
				err_d    = 1'b0;
				step_d   = '0;
				tick_d   = '0;
				enter    = 1'b1;
				enter_sg = program_stage(operation, 3'd0);
			end
		end else if (phase_q == PH_AKP) begin
			// Poll acknowledge while SCL is high
			if (!sda_in) begin
				scl_d   = 1'b0;
				tick_d  = '0;
				phase_d = PH_AK3;
			end else if (ackw_q >= cfg.ack_timeout) begin
				err_d   = 1'b1;
				scl_d   = 1'b0;
				tick_d  = '0;
				phase_d = PH_AKF;
			end else begin
				ackw_d = ackw_q + 8'd1;
			end
		end else if (tick_nx >= {1'b0, hold}) begin
			// Phase time is up: advance
			tick_d = '0;
			unique case (phase_q)
				PH_ST0: begin scl_d = 1'b1; phase_d = PH_ST1; end
				PH_ST1: begin sda_d = 1'b0; phase_d = PH_ST2; end
				PH_ST2: begin scl_d = 1'b0; phase_d = PH_ST3; end
				PH_ST3, PH_AK3, PH_NK1: begin
					step_d   = step_q + 3'd1;
					enter    = 1'b1;
					enter_sg = program_stage(cmd_q, step_q + 3'd1);
				end
				PH_BT0: begin scl_d = 1'b1; phase_d = PH_BT1; end
				PH_BT1: begin scl_d = 1'b0; phase_d = PH_BT2; end
				PH_BT2: begin
					bit_d = bit_nx;
					if (bit_nx < 4'd8) begin
						shift_d = shift_nx;
						sda_d   = shift_nx[7];
						phase_d = PH_BT0;
					end else begin
						sda_d   = 1'b1;
						phase_d = PH_AK0;
					end
				end
				PH_AK0: begin scl_d = 1'b1; phase_d = PH_AK1; end
				PH_AK1: begin ackw_d = '0; phase_d = PH_AKP; end
				PH_AKF: begin enter = 1'b1; enter_sg = SG_STOP; end
				PH_RD0: begin scl_d = 1'b1; phase_d = PH_RD1; end
				PH_RD1: begin
					shift_d = {shift_q[6:0], sda_in};
					phase_d = PH_RD2;
				end
				PH_RD2: begin
					bit_d = bit_nx;
					scl_d = 1'b0;
					if (bit_nx < 4'd8) begin
						phase_d = PH_RD0;
					end else begin
						recv_d  = shift_q;
						sda_d   = 1'b1;
						phase_d = PH_NK0;
					end
				end
				PH_NK0: begin scl_d = 1'b1; phase_d = PH_NK1; end
				PH_SP0: begin scl_d = 1'b1; phase_d = PH_SP1; end
				PH_SP1: begin sda_d = 1'b1; phase_d = PH_SP2; end
				PH_RC0: begin scl_d = 1'b0; phase_d = PH_RC1; end
				PH_RC1: begin scl_d = 1'b1; phase_d = PH_RC2; end
				PH_RC2: begin
					bit_d = bit_nx;
					scl_d = 1'b0;
					if (bit_nx < RECOVERY_PULSES) begin
						phase_d = PH_RC1;
					end else begin
						sda_d   = 1'b0;
						phase_d = PH_RC3;
					end
				end
				PH_RC3: begin scl_d = 1'b1; phase_d = PH_RC4; end
				PH_RC4: begin sda_d = 1'b1; phase_d = PH_IDLE; fin = 1'b1; end
				default: begin phase_d = PH_IDLE; fin = 1'b1; end
			endcase
		end else begin
			tick_d = tick_nx[15:0];
		end

		// Enter the next part of the command
		if (enter) begin
			unique case (enter_sg)
				SG_START: begin sda_d = 1'b1; phase_d = PH_ST0; end
				SG_DEV:   begin send = 1'b1; send_b = dev_d; end
				SG_REG:   begin send = 1'b1; send_b = reg_d; end
				SG_DATA:  begin send = 1'b1; send_b = data_d; end
				SG_DEV1:  begin send = 1'b1; send_b = dev_d + 8'd1; end
				SG_READ: begin
					shift_d = '0;
					bit_d   = '0;
					sda_d   = 1'b1;
					scl_d   = 1'b0;
					phase_d = PH_RD0;
				end
				SG_STOP: begin scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_SP0; end
				SG_RECOVER: begin
					bit_d   = '0;
					scl_d   = 1'b1;
					sda_d   = 1'b1;
					phase_d = PH_RC0;
				end
				default: begin phase_d = PH_IDLE; fin = 1'b1; end
			endcase
			// Load a byte for transmission, MSB first
			if (send) begin
				shift_d = send_b;
				bit_d   = '0;
				scl_d   = 1'b0;
				sda_d   = send_b[7];
				phase_d = PH_BT0;
			end
		end
	end

	// Result of this tick
	always_comb begin
		res.scl       = scl_d;
		res.sda       = sda_d;
		res.busy      = (phase_d != PH_IDLE);
		res.done      = fin;
		res.read_data = recv_d;
		res.ack_error = err_d;
	end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the I2C master register access block.
// Drives one bus tick per request, models the bus sequencer in place and checks each result.
// Depends on i2cm_pkg and i2c_master_register_access_top.
`timescale 1ns / 100ps

module tb_top;
	import i2cm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_PLAN = 13;

	// One bus tick as driven on the request channel
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] dev;
		logic [7:0] rg;
		logic [7:0] dat;
		logic       sd;
	} tick_t;

	// One directed command: target bytes, where the acknowledge fails, the byte
	// the device returns, and optionally the status pinned on the closing tick
	typedef struct {
		logic [1:0] op;
		logic [7:0] dev;
		logic [7:0] rg;
		logic [7:0] dat;
		int         nack_at;
		logic [7:0] rd_byte;
		bit         pin_en;
		res_t       pin_res;
	} cmd_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_NONE;
	logic [7:0]  device_address = 8'h00;
	logic [7:0]  register_address = 8'h00;
	logic [7:0]  write_data = 8'h00;
	logic        sda_in = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_error;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	i2c_master_register_access_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .device_address(device_address),
		.register_address(register_address), .write_data(write_data), .sda_in(sda_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.scl_out(scl_out), .sda_out(sda_out), .busy_res(busy_res), .done_res(done_res),
		.read_data(read_data), .ack_error(ack_error),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Line levels and status due after each accepted tick, oldest first
	res_t tick_out_q [$];
	int   bad_cnt = 0;
	int   tick_total = 0;
	int   cycle_cnt = 0;
	logic calm = 1'b0;

	// ---------------- bus sequencer model ----------------
	logic [15:0] cfg_phase = PHASE_TICKS_RST;
	logic [15:0] cfg_rec = RECOVERY_TICKS_RST;
	logic [7:0]  cfg_tmo = ACK_TIMEOUT_RST;

	phase_t      ph = PH_IDLE;
	logic [3:0]  bit_no = 4'd0;
	logic [7:0]  shreg = 8'h00;
	logic [15:0] hold_cnt = 16'd0;
	logic [7:0]  poll_cnt = 8'd0;
	logic [7:0]  dev_b = 8'h00, reg_b = 8'h00, dat_b = 8'h00, rx_byte = 8'h00;
	logic [1:0]  cmd_b = OP_NONE;
	logic [2:0]  part = 3'd0;
	logic        err_f = 1'b0, scl_l = 1'b1, sda_l = 1'b1, fin_f = 1'b0;

	// Parts of each command in order: write, read, recovery
	stage_t cmd_plan [3][8] = '{
		'{SG_START, SG_DEV, SG_REG, SG_DATA, SG_STOP, SG_END, SG_END, SG_END},
		'{SG_START, SG_DEV, SG_REG, SG_START, SG_DEV1, SG_READ, SG_STOP, SG_END},
		'{SG_RECOVER, SG_END, SG_END, SG_END, SG_END, SG_END, SG_END, SG_END}
	};

	function automatic void load_byte(input logic [7:0] b);
		shreg = b;
		bit_no = 4'd0;
		scl_l = 1'b0;
		sda_l = b[7];
		ph = PH_BT0;
	endfunction

	function automatic void open_part(input stage_t s);
		case (s)
			SG_START: begin
				sda_l = 1'b1;
				ph = PH_ST0;
			end
			SG_DEV: load_byte(dev_b);
			SG_REG: load_byte(reg_b);
			SG_DATA: load_byte(dat_b);
			SG_DEV1: load_byte(dev_b + 8'd1);
			SG_READ: begin
				shreg = 8'h00;
				bit_no = 4'd0;
				sda_l = 1'b1;
				scl_l = 1'b0;
				ph = PH_RD0;
			end
			SG_STOP: begin
				scl_l = 1'b0;
				sda_l = 1'b0;
				ph = PH_SP0;
			end
			SG_RECOVER: begin
				bit_no = 4'd0;
				scl_l = 1'b1;
				sda_l = 1'b1;
				ph = PH_RC0;
			end
			default: begin
				ph = PH_IDLE;
				fin_f = 1'b1;
			end
		endcase
	endfunction

	function automatic void next_part();
		part = part + 3'd1;
		open_part(cmd_plan[cmd_b - 2'd1][part]);
	endfunction

	// Ticks each level is held; zero counts as one
	function automatic int phase_len(input phase_t p);
		int h;
		h = (p >= PH_RC0) ? int'(cfg_rec) : int'(cfg_phase);
		return (h == 0) ? 1 : h;
	endfunction

	function automatic void advance(input logic sd);
		case (ph)
			PH_ST0: begin scl_l = 1'b1; ph = PH_ST1; end
			PH_ST1: begin sda_l = 1'b0; ph = PH_ST2; end
			PH_ST2: begin scl_l = 1'b0; ph = PH_ST3; end
			PH_ST3: next_part();
			PH_BT0: begin scl_l = 1'b1; ph = PH_BT1; end
			PH_BT1: begin scl_l = 1'b0; ph = PH_BT2; end
			PH_BT2: begin
				bit_no = bit_no + 4'd1;
				if (bit_no < 4'd8) begin
					shreg = shreg << 1;
					sda_l = shreg[7];
					ph = PH_BT0;
				end else begin
					sda_l = 1'b1;
					ph = PH_AK0;
				end
			end
			PH_AK0: begin scl_l = 1'b1; ph = PH_AK1; end
			PH_AK1: begin poll_cnt = 8'd0; ph = PH_AKP; end
			PH_AK3: next_part();
			PH_AKF: open_part(SG_STOP);
			PH_RD0: begin scl_l = 1'b1; ph = PH_RD1; end
			PH_RD1: begin shreg = {shreg[6:0], sd}; ph = PH_RD2; end
			PH_RD2: begin
				bit_no = bit_no + 4'd1;
				if (bit_no < 4'd8) begin
					scl_l = 1'b0;
					ph = PH_RD0;
				end else begin
					rx_byte = shreg;
					scl_l = 1'b0;
					sda_l = 1'b1;
					ph = PH_NK0;
				end
			end
			PH_NK0: begin scl_l = 1'b1; ph = PH_NK1; end
			PH_NK1: next_part();
			PH_SP0: begin scl_l = 1'b1; ph = PH_SP1; end
			PH_SP1: begin sda_l = 1'b1; ph = PH_SP2; end
			PH_RC0: begin scl_l = 1'b0; ph = PH_RC1; end
			PH_RC1: begin scl_l = 1'b1; ph = PH_RC2; end
			PH_RC2: begin
				bit_no = bit_no + 4'd1;
				if (bit_no < RECOVERY_PULSES) begin
					scl_l = 1'b0;
					ph = PH_RC1;
				end else begin
					scl_l = 1'b0;
					sda_l = 1'b0;
					ph = PH_RC3;
				end
			end
			PH_RC3: begin scl_l = 1'b1; ph = PH_RC4; end
			PH_RC4: begin
				sda_l = 1'b1;
				ph = PH_IDLE;
				fin_f = 1'b1;
			end
			default: begin
				ph = PH_IDLE;
				fin_f = 1'b1;
			end
		endcase
	endfunction

	// Apply one bus tick and return the levels and status after it
	function automatic res_t bus_tick(input tick_t t);
		res_t r;
		int   nxt;
		fin_f = 1'b0;
		if (ph == PH_IDLE) begin
			if (t.op != OP_NONE) begin
				cmd_b = t.op;
				dev_b = t.dev;
				reg_b = t.rg;
				dat_b = t.dat;
				err_f = 1'b0;
				part = 3'd0;
				hold_cnt = 16'd0;
				open_part(cmd_plan[t.op - 2'd1][0]);
			end
		end else if (ph == PH_AKP) begin
			// Poll acknowledge once per tick while SCL is high
			if (!t.sd) begin
				scl_l = 1'b0;
				hold_cnt = 16'd0;
				ph = PH_AK3;
			end else if (poll_cnt >= cfg_tmo) begin
				err_f = 1'b1;
				scl_l = 1'b0;
				hold_cnt = 16'd0;
				ph = PH_AKF;
			end else begin
				poll_cnt = poll_cnt + 8'd1;
			end
		end else begin
			nxt = int'(hold_cnt) + 1;
			if (nxt >= phase_len(ph)) begin
				hold_cnt = 16'd0;
				advance(t.sd);
			end else begin
				hold_cnt = nxt[15:0];
			end
		end
		r.scl = scl_l;
		r.sda = sda_l;
		r.busy = (ph != PH_IDLE);
		r.done = fin_f;
		r.read_data = rx_byte;
		r.ack_error = err_f;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// SDA seen by the master: the slave acknowledges most bytes at random, withholds the ack on
	// the chosen byte, or sends the read byte MSB first
	function automatic logic pick_sda(input int nack_at, input logic [7:0] rd_byte,
		input bit noisy);
		int ack_no;
		if (noisy)
			return 1'($urandom_range(0, 1));
		case (ph)
			PH_AKP: begin
				ack_no = (cmd_b == OP_READ && part == 3'd4) ? 3 : int'(part);
				if (ack_no == nack_at)
					return 1'b1;
				return ($urandom_range(0, 9) >= 3) ? 1'b0 : 1'b1;
			end
			PH_RD0, PH_RD1, PH_RD2: return rd_byte[3'd7 - bit_no[2:0]];
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic cmd_row_t mk_row(input logic [1:0] op, input logic [7:0] dev,
		input logic [7:0] rg, input logic [7:0] dat, input int nack_at,
		input logic [7:0] rd_byte, input bit pin_en, input logic [7:0] exp_rd,
		input logic exp_err);
		cmd_row_t c;
		c.op = op;
		c.dev = dev;
		c.rg = rg;
		c.dat = dat;
		c.nack_at = nack_at;
		c.rd_byte = rd_byte;
		c.pin_en = pin_en;
		c.pin_res.scl = 1'b1;
		c.pin_res.sda = 1'b1;
		c.pin_res.busy = 1'b0;
		c.pin_res.done = (op != OP_NONE);
		c.pin_res.read_data = exp_rd;
		c.pin_res.ack_error = exp_err;
		return c;
	endfunction

	// Drive one request, hold it until taken, then record the status it causes
	task automatic push_tick(input tick_t t, input bit pin_en, input res_t pin_res);
		res_t r;
		if (!calm && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= t.op;
		device_address <= t.dev;
		register_address <= t.rg;
		write_data <= t.dat;
		sda_in <= t.sd;
		do @(posedge clk); while (in_stall);
		r = bus_tick(t);
		// a pinned status replaces the modeled one on the closing tick
		tick_out_q.push_back((pin_en && !r.busy) ? pin_res : r);
		tick_total++;
	endtask

	// Start a command and keep ticking until the sequencer is idle again
	task automatic run_cmd(input cmd_row_t c, input bit noisy);
		tick_t t;
		t.op = c.op;
		t.dev = c.dev;
		t.rg = c.rg;
		t.dat = c.dat;
		t.sd = pick_sda(c.nack_at, c.rd_byte, noisy);
		push_tick(t, c.pin_en, c.pin_res);
		while (ph != PH_IDLE) begin
			// operation and bytes are ignored while busy: drive noise
			t.op = 2'($urandom_range(0, 3));
			t.dev = pick_byte();
			t.rg = pick_byte();
			t.dat = pick_byte();
			t.sd = pick_sda(c.nack_at, c.rd_byte, noisy);
			push_tick(t, c.pin_en, c.pin_res);
		end
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (tick_out_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready
	task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'h0000, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PHASE_TICKS: cfg_phase = val;
			REG_RECOVERY_TICKS: cfg_rec = val;
			REG_ACK_TIMEOUT: cfg_tmo = val[7:0];
			default: ;
		endcase
	endtask

	// One configuration setting followed by random commands
	task automatic run_phase(input logic [15:0] ph_ticks, input logic [15:0] rec_ticks,
		input logic [7:0] tmo, input bit allow_rw, input bit allow_rc, input int n_ticks,
		input logic calm_on);
		cmd_row_t c;
		int       start;
		settle();
		set_reg(REG_PHASE_TICKS, ph_ticks);
		set_reg(REG_RECOVERY_TICKS, rec_ticks);
		set_reg(REG_ACK_TIMEOUT, {8'h00, tmo});
		calm <= calm_on;
		start = tick_total;
		while (tick_total - start < n_ticks) begin
			if ($urandom_range(0, 9) == 0)
				c.op = OP_NONE;
			else if (allow_rw && allow_rc)
				c.op = 2'($urandom_range(1, 3));
			else if (allow_rw)
				c.op = 2'($urandom_range(1, 2));
			else
				c.op = OP_RECOVER;
			c.dev = pick_byte();
			c.rg = pick_byte();
			c.dat = pick_byte();
			c.nack_at = ($urandom_range(0, 99) < 12) ? int'($urandom_range(1, 3)) : 0;
			c.rd_byte = pick_byte();
			c.pin_en = 1'b0;
			c.pin_res = '0;
			run_cmd(c, $urandom_range(0, 99) < 15);
		end
	endtask

	// ---------------- result checking ----------------
	function automatic string show(input res_t r);
		return $sformatf("scl=%0b sda=%0b busy=%0b done=%0b rd=%02h err=%0b",
			r.scl, r.sda, r.busy, r.done, r.read_data, r.ack_error);
	endfunction

	task automatic flag_bad(input string msg);
		bad_cnt++;
		if (bad_cnt <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.scl = scl_out;
			got.sda = sda_out;
			got.busy = busy_res;
			got.done = done_res;
			got.read_data = read_data;
			got.ack_error = ack_error;
			if (tick_out_q.size() == 0) begin
				flag_bad($sformatf("result with no request pending: %s", show(got)));
			end else begin
				want = tick_out_q.pop_front();
				if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
					got.done !== want.done || got.read_data !== want.read_data ||
					got.ack_error !== want.ack_error)
					flag_bad($sformatf("mismatch: want %s, got %s", show(want), show(got)));
			end
		end
	end

	// Random backpressure on the result side
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 9);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("i2c_master_register_access_top regression: fail");
			$finish;
		end
	end

	// ---------------- main sequence ----------------
	initial begin : stimulus
		cmd_row_t plan [N_PLAN];
		int       i;
		plan = '{
			// idle tick right after reset: lines released, nothing set
			mk_row(OP_NONE,    8'h00, 8'h00, 8'h00, 0, 8'h00, 1, 8'h00, 1'b0),
			mk_row(OP_WRITE,   8'h00, 8'h00, 8'h00, 0, 8'h00, 1, 8'h00, 1'b0),
			mk_row(OP_WRITE,   8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 1, 8'h00, 1'b0),
			// device byte plus one wraps to zero
			mk_row(OP_READ,    8'hFF, 8'h5A, 8'h00, 0, 8'hFF, 1, 8'hFF, 1'b0),
			mk_row(OP_READ,    8'h7E, 8'hC3, 8'h3C, 0, 8'hA5, 1, 8'hA5, 1'b0),
			mk_row(OP_RECOVER, 8'h12, 8'h34, 8'h56, 0, 8'h00, 1, 8'hA5, 1'b0),
			// acknowledge timeouts on device and data byte
			mk_row(OP_WRITE,   8'h50, 8'h01, 8'h80, 1, 8'h00, 1, 8'hA5, 1'b1),
			mk_row(OP_WRITE,   8'h50, 8'h02, 8'h7F, 3, 8'h00, 1, 8'hA5, 1'b1),
			// failed reads keep the last read byte
			mk_row(OP_READ,    8'hA0, 8'h10, 8'h00, 2, 8'h3C, 1, 8'hA5, 1'b1),
			mk_row(OP_READ,    8'hA0, 8'h10, 8'h00, 3, 8'h3C, 1, 8'hA5, 1'b1),
			mk_row(OP_NONE,    8'hFF, 8'hFF, 8'hFF, 0, 8'h00, 1, 8'hA5, 1'b1),
			// error flag clears when the next command starts
			mk_row(OP_READ,    8'hA1, 8'h20, 8'h00, 0, 8'h5A, 1, 8'h5A, 1'b0),
			mk_row(OP_RECOVER, 8'h00, 8'h00, 8'h00, 0, 8'h00, 1, 8'h5A, 1'b0)
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands: the first two at reset configuration
		for (i = 0; i < 2; i++)
			run_cmd(plan[i], 1'b0);

		// the rest at the fastest bit timing
		settle();
		set_reg(REG_PHASE_TICKS, 16'd1);
		set_reg(REG_RECOVERY_TICKS, 16'd1);
		set_reg(REG_ACK_TIMEOUT, 16'd16);
		for (i = 2; i < N_PLAN; i++)
			run_cmd(plan[i], 1'b0);

		// Random commands over several settings
		run_phase(16'd1, 16'd1, 8'd3, 1'b1, 1'b1, 80, 1'b0);
		run_phase(16'd0, 16'd0, 8'd0, 1'b1, 1'b1, 50, 1'b0);
		// slowest bit timing: only recovery runs, it uses its own timing
		run_phase(16'd65535, 16'd2, 8'd255, 1'b0, 1'b1, 30, 1'b0);
		// slowest recovery timing: only reads and writes run
		run_phase(16'd1, 16'd65535, 8'd255, 1'b1, 1'b0, 40, 1'b0);
		run_phase(16'd1, 16'd5, 8'd1, 1'b1, 1'b1, 120, 1'b1);
		settle();

		if (bad_cnt == 0)
			$display("i2c_master_register_access_top regression: pass");
		else
			$display("i2c_master_register_access_top regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
design/i2cm_pkg.sv
design/i2cm_seq.sv
design/i2c_master_register_access_top.sv
tb/sv/tb_top.sv
